[design/vector3_axis_rotation_unit_defines.svh]
// assertion macros for the vector axis rotation unit
`ifndef VECTOR3_AXIS_ROTATION_UNIT_DEFINES_SVH
`define VECTOR3_AXIS_ROTATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define VR3_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define VR3_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VR3_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VR3_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[design/vr3_pkg.sv]
// shared types, constants and the arctangent table of the rotation unit
package vr3_pkg;

  localparam int FIELD_W         = 32;
  localparam int ANGLE_W         = 16;
  localparam int AXIS_W          = 2;
  localparam int TRIG_W          = 32;
  localparam int TRIG_FRAC       = 30;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int TRIG_STEPS_DEF  = 16;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef logic signed [FIELD_W-1:0] field_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
    logic                     neg;
  } cordic_t;

  // atan(2^-i) in units of 2^-22 degree
  function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [4:0] idx);
    logic signed [TRIG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'sd188743680;
      5'd1:    v = 32'sd111421900;
      5'd2:    v = 32'sd58872272;
      5'd3:    v = 32'sd29884485;
      5'd4:    v = 32'sd15000234;
      5'd5:    v = 32'sd7507429;
      5'd6:    v = 32'sd3754631;
      5'd7:    v = 32'sd1877430;
      5'd8:    v = 32'sd938729;
      5'd9:    v = 32'sd469366;
      5'd10:   v = 32'sd234683;
      5'd11:   v = 32'sd117342;
      5'd12:   v = 32'sd58671;
      5'd13:   v = 32'sd29335;
      5'd14:   v = 32'sd14668;
      5'd15:   v = 32'sd7334;
      5'd16:   v = 32'sd3667;
      5'd17:   v = 32'sd1833;
      5'd18:   v = 32'sd917;
      5'd19:   v = 32'sd458;
      5'd20:   v = 32'sd229;
      5'd21:   v = 32'sd115;
      5'd22:   v = 32'sd57;
      5'd23:   v = 32'sd29;
      5'd24:   v = 32'sd14;
      5'd25:   v = 32'sd7;
      5'd26:   v = 32'sd4;
      5'd27:   v = 32'sd2;
      5'd28:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[design/vr3_cordic_step.sv]
// one registered cordic rotation step
module vr3_cordic_step #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  vr3_pkg::cordic_t cord_i,
  output vr3_pkg::cordic_t cord_o
);

  localparam logic signed [vr3_pkg::TRIG_W-1:0] Atan = vr3_pkg::atan_lut(5'(STEP));

  logic signed [vr3_pkg::TRIG_W-1:0] xi, yi, zi, dx, dy;
  vr3_pkg::cordic_t                  cord_d, cord_q;

  assign xi = cord_i.x;
  assign yi = cord_i.y;
  assign zi = cord_i.z;
  assign dx = yi >>> STEP;
  assign dy = xi >>> STEP;

  always_comb begin
    cord_d.neg = cord_i.neg;
    if (zi >= 0) begin
      cord_d.x = xi - dx;
      cord_d.y = yi + dy;
      cord_d.z = zi - Atan;
    end else begin
      cord_d.x = xi + dx;
      cord_d.y = yi - dy;
      cord_d.z = zi + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign cord_o = cord_q;

endmodule

[design/vector3_axis_rotation_unit.sv]
// Rotates a signed Q15.16 vector about the x, y or z axis by an angle in 1/64 degree.
// The block takes one item per cycle while the output side does not stall and returns the
// results in order: one stage reduces the angle, one cordic step per stage forms cosine and
// sine, then one stage each selects operands, multiplies, rounds and saturates. Stalled
// stages hold their items and empty stages still fill, so the block keeps taking items while
// a result waits at the output.

`include "vector3_axis_rotation_unit_defines.svh"

module vector3_axis_rotation_unit #(
  parameter int COORD_WIDTH = vr3_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_STEPS  = vr3_pkg::TRIG_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // angle_deg[15:0], in_x[47:16], in_y[79:48], in_z[111:80]
  input  logic [111:0] s_axis_tdata_i,
  // axis_sel[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  m_axis_tdata_o,
  // saturated[0]
  output logic [0:0]   m_axis_tuser_o
);

  localparam int CW      = (COORD_WIDTH < vr3_pkg::FIELD_W) ? COORD_WIDTH : vr3_pkg::FIELD_W;
  localparam int T       = TRIG_STEPS;
  localparam int SFin    = T + 1;
  localparam int SMul    = T + 2;
  localparam int SSum    = T + 3;
  localparam int SOut    = T + 4;
  localparam int L       = T + 5;
  localparam int AngW    = vr3_pkg::ANGLE_W;
  localparam int FW      = vr3_pkg::FIELD_W;
  localparam int TW      = vr3_pkg::TRIG_W;
  localparam int RedW    = AngW + 1;
  localparam int PW      = CW + TW;
  localparam int SW      = PW + 1;
  localparam int RW      = SW - vr3_pkg::TRIG_FRAC;

  localparam logic signed [RedW-1:0] FullTurn    = RedW'(23040);
  localparam logic signed [RedW-1:0] TwoTurns    = RedW'(46080);
  localparam logic signed [RedW-1:0] HalfTurn    = RedW'(11520);
  localparam logic signed [RedW-1:0] QuarterTurn = RedW'(5760);
  localparam int                     AngShift    = 16;
  localparam logic signed [SW-1:0]   RndBias     = SW'(1) <<< (vr3_pkg::TRIG_FRAC - 1);
  localparam logic signed [RW-1:0]   CoordHi     = RW'(signed'({1'b0, {(CW-1){1'b1}}}));
  localparam logic signed [RW-1:0]   CoordLo     = RW'(signed'({1'b1, {(CW-1){1'b0}}}));

  // handshake and valid chain
  logic [L-1:0] vld_q, vld_d, adv;

  assign adv[L-1] = !vld_q[L-1] || m_axis_tready_i;
  for (genvar k = 0; k < L - 1; k++) begin : g_adv
    assign adv[k] = !vld_q[k] || adv[k+1];
  end

  always_comb begin
    vld_d[0] = adv[0] ? s_axis_tvalid_i : vld_q[0];
    for (int k = 1; k < L; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready_o = adv[0];

  // input fields
  logic signed [AngW-1:0] ang;
  logic signed [CW-1:0]   in_x, in_y, in_z;

  assign ang  = s_axis_tdata_i[AngW-1:0];
  assign in_x = s_axis_tdata_i[AngW +: CW];
  assign in_y = s_axis_tdata_i[AngW + FW +: CW];
  assign in_z = s_axis_tdata_i[AngW + 2*FW +: CW];

  // angle reduction and quadrant fold
  logic signed [RedW-1:0] ang_e, ang_m, ang_f, ang_r;
  logic                   fold_neg;
  vr3_pkg::cordic_t       cord_d;
  vr3_pkg::cordic_t       cord_q [0:T];

  assign ang_e = RedW'(ang);

  always_comb begin
    priority if (ang_e < -FullTurn) begin
      ang_m = ang_e + TwoTurns;
    end else if (ang_e < 0) begin
      ang_m = ang_e + FullTurn;
    end else if (ang_e >= FullTurn) begin
      ang_m = ang_e - FullTurn;
    end else begin
      ang_m = ang_e;
    end
    ang_f = (ang_m >= HalfTurn) ? ang_m - FullTurn : ang_m;
    priority if (ang_f > QuarterTurn) begin
      ang_r    = ang_f - HalfTurn;
      fold_neg = 1'b1;
    end else if (ang_f < -QuarterTurn) begin
      ang_r    = ang_f + HalfTurn;
      fold_neg = 1'b1;
    end else begin
      ang_r    = ang_f;
      fold_neg = 1'b0;
    end
    cord_d.x   = vr3_pkg::CORDIC_GAIN;
    cord_d.y   = '0;
    cord_d.z   = TW'(ang_r) <<< AngShift;
    cord_d.neg = fold_neg;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cord_q[0] <= cord_d;
    end
  end

  for (genvar k = 1; k <= T; k++) begin : g_step
    vr3_cordic_step #(
      .STEP(k - 1)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (adv[k]),
      .cord_i(cord_q[k-1]),
      .cord_o(cord_q[k])
    );
  end

  // coordinates and axis travel beside the trig pipeline
  logic [vr3_pkg::AXIS_W-1:0] axis_q [0:SSum];
  logic signed [CW-1:0]       cx_q   [0:SSum];
  logic signed [CW-1:0]       cy_q   [0:SSum];
  logic signed [CW-1:0]       cz_q   [0:SSum];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      axis_q[0] <= s_axis_tuser_i;
      cx_q[0]   <= in_x;
      cy_q[0]   <= in_y;
      cz_q[0]   <= in_z;
    end
  end

  for (genvar k = 1; k <= SSum; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        axis_q[k] <= axis_q[k-1];
        cx_q[k]   <= cx_q[k-1];
        cy_q[k]   <= cy_q[k-1];
        cz_q[k]   <= cz_q[k-1];
      end
    end
  end

  // sign fix and operand select
  logic signed [TW-1:0] c_d, s_d, c_q, s_q;
  logic signed [CW-1:0] opu_d, opv_d, opu_q, opv_q;
  logic signed [TW-1:0] cord_x, cord_y;

  assign cord_x = cord_q[T].x;
  assign cord_y = cord_q[T].y;
  assign c_d    = cord_q[T].neg ? -cord_x : cord_x;
  assign s_d    = cord_q[T].neg ? -cord_y : cord_y;

  always_comb begin
    unique case (axis_q[T])
      vr3_pkg::AXIS_X: begin
        opu_d = cy_q[T];
        opv_d = cz_q[T];
      end
      vr3_pkg::AXIS_Y: begin
        opu_d = cz_q[T];
        opv_d = cx_q[T];
      end
      default: begin
        opu_d = cx_q[T];
        opv_d = cy_q[T];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[SFin]) begin
      c_q   <= c_d;
      s_q   <= s_d;
      opu_q <= opu_d;
      opv_q <= opv_d;
    end
  end

  // products
  logic signed [PW-1:0] puc_q, pvs_q, pus_q, pvc_q;

  always_ff @(posedge clk_i) begin
    if (adv[SMul]) begin
      puc_q <= PW'(opu_q) * PW'(c_q);
      pvs_q <= PW'(opv_q) * PW'(s_q);
      pus_q <= PW'(opu_q) * PW'(s_q);
      pvc_q <= PW'(opv_q) * PW'(c_q);
    end
  end

  // round half up at the coordinate lsb
  logic signed [SW-1:0] su, sv;
  logic signed [RW-1:0] ru_q, rv_q;

  assign su = SW'(puc_q) - SW'(pvs_q) + RndBias;
  assign sv = SW'(pus_q) + SW'(pvc_q) + RndBias;

  always_ff @(posedge clk_i) begin
    if (adv[SSum]) begin
      ru_q <= su[SW-1:vr3_pkg::TRIG_FRAC];
      rv_q <= sv[SW-1:vr3_pkg::TRIG_FRAC];
    end
  end

  // saturate and place the rotated pair
  logic signed [CW-1:0] cu, cv;
  logic                 hit_u, hit_v;
  vr3_pkg::field_t      ox_d, oy_d, oz_d, ox_q, oy_q, oz_q;
  logic                 sat_d, sat_q;

  always_comb begin
    hit_u = (ru_q > CoordHi) || (ru_q < CoordLo);
    hit_v = (rv_q > CoordHi) || (rv_q < CoordLo);
    cu    = (ru_q > CoordHi) ? CoordHi[CW-1:0] :
            (ru_q < CoordLo) ? CoordLo[CW-1:0] : ru_q[CW-1:0];
    cv    = (rv_q > CoordHi) ? CoordHi[CW-1:0] :
            (rv_q < CoordLo) ? CoordLo[CW-1:0] : rv_q[CW-1:0];
    ox_d  = vr3_pkg::field_t'(cx_q[SSum]);
    oy_d  = vr3_pkg::field_t'(cy_q[SSum]);
    oz_d  = vr3_pkg::field_t'(cz_q[SSum]);
    sat_d = hit_u || hit_v;
    unique case (axis_q[SSum])
      vr3_pkg::AXIS_X: begin
        oy_d = vr3_pkg::field_t'(cu);
        oz_d = vr3_pkg::field_t'(cv);
      end
      vr3_pkg::AXIS_Y: begin
        oz_d = vr3_pkg::field_t'(cu);
        ox_d = vr3_pkg::field_t'(cv);
      end
      vr3_pkg::AXIS_Z: begin
        ox_d = vr3_pkg::field_t'(cu);
        oy_d = vr3_pkg::field_t'(cv);
      end
      default: begin
        sat_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[SOut]) begin
      ox_q  <= ox_d;
      oy_q  <= oy_d;
      oz_q  <= oz_d;
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid_o   = vld_q[SOut];
  assign m_axis_tdata_o    = {oz_q, oy_q, ox_q};
  assign m_axis_tuser_o[0] = sat_q;

  // a clipped item carries a coordinate at a range limit
  vr3_pkg::field_t lim_hi, lim_lo;
  logic            at_limit;

  assign lim_hi   = vr3_pkg::field_t'(CoordHi[CW-1:0]);
  assign lim_lo   = vr3_pkg::field_t'(CoordLo[CW-1:0]);
  assign at_limit = (ox_q == lim_hi) || (ox_q == lim_lo) || (oy_q == lim_hi) ||
                    (oy_q == lim_lo) || (oz_q == lim_hi) || (oz_q == lim_lo);

  `VR3_ASSERT_IMP(a_ready_when_out_free, clk_i, rst_ni, !vld_q[SOut], s_axis_tready_o, "input stalled with free output stage")
  `VR3_ASSERT_NXT(a_accept_fills_stage0, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, vld_q[0], "accepted item lost at first stage")
  `VR3_ASSERT_IMP(a_sat_at_limit, clk_i, rst_ni, m_axis_tvalid_o && sat_q, at_limit, "saturated flag without clipped coordinate")

endmodule

[verif/vector3_axis_rotation_unit_checker.sv]
// checker for the vector axis rotation unit: predicts each rotated vector and compares results
`timescale 1ns / 1ps

module vector3_axis_rotation_unit_checker
  import vr3_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TRIG_STEPS  = TRIG_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  // angle_deg[15:0], in_x[47:16], in_y[79:48], in_z[111:80]
  input  logic [111:0] s_axis_tdata_i,
  // axis_sel[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  input  logic [95:0]  m_axis_tdata_i,
  // saturated[0]
  input  logic [0:0]   m_axis_tuser_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int CW           = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;

  typedef struct packed {
    field_t x;
    field_t y;
    field_t z;
    logic   sat;
  } rotated_t;

  rotated_t rotated_q[$];
  rotated_t want;
  rotated_t got;
  int       failures;

  // atan(2^-i) in 2^-22 degree
  function automatic longint atan_units(input int i);
    case (i)
      0:  return 188743680;
      1:  return 111421900;
      2:  return 58872272;
      3:  return 29884485;
      4:  return 15000234;
      5:  return 7507429;
      6:  return 3754631;
      7:  return 1877430;
      8:  return 938729;
      9:  return 469366;
      10: return 234683;
      11: return 117342;
      12: return 58671;
      13: return 29335;
      14: return 14668;
      15: return 7334;
      16: return 3667;
      17: return 1833;
      18: return 917;
      19: return 458;
      20: return 229;
      21: return 115;
      22: return 57;
      23: return 29;
      24: return 14;
      25: return 7;
      26: return 4;
      27: return 2;
      28: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void cordic_cos_sin(input logic signed [ANGLE_W-1:0] angle,
                                         output longint c, output longint s);
    int     a;
    int     i;
    bit     flip;
    longint cx;
    longint sy;
    longint rem;
    longint dx;
    longint dy;
    a    = int'(angle) % FULL_TURN;
    flip = 1'b0;
    if (a < 0) a += FULL_TURN;
    if (a >= HALF_TURN) a -= FULL_TURN;
    // fold into [-90, +90] degrees, negating the result
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1'b1;
    end
    cx  = longint'(CORDIC_GAIN);
    sy  = 0;
    rem = longint'(a) * 65536;
    for (i = 0; i < TRIG_STEPS && i < 32; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (rem >= 0) begin
        cx  -= dx;
        sy  += dy;
        rem -= atan_units(i);
      end else begin
        cx  += dx;
        sy  -= dy;
        rem += atan_units(i);
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -sy : sy;
  endfunction

  function automatic longint to_coord(input field_t v);
    longint t;
    t = longint'(v);
    t = (t <<< (64 - CW)) >>> (64 - CW);
    return t;
  endfunction

  // round at 2^-30 and clip to the coordinate range
  function automatic longint product_sum_sat(input longint a, input longint ca,
                                             input longint b, input longint cb,
                                             inout logic sat);
    longint v;
    longint hi;
    longint lo;
    v  = (a * ca + b * cb + (longint'(1) <<< 29)) >>> 30;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic rotated_t rotate_vector(input logic [AXIS_W-1:0] axis,
                                             input logic signed [ANGLE_W-1:0] angle,
                                             input field_t fx, input field_t fy,
                                             input field_t fz);
    longint   x;
    longint   y;
    longint   z;
    longint   c;
    longint   s;
    longint   rx;
    longint   ry;
    longint   rz;
    logic     sat;
    rotated_t r;
    x   = to_coord(fx);
    y   = to_coord(fy);
    z   = to_coord(fz);
    rx  = x;
    ry  = y;
    rz  = z;
    sat = 1'b0;
    cordic_cos_sin(angle, c, s);
    case (axis)
      AXIS_X: begin
        ry = product_sum_sat(y, c, z, -s, sat);
        rz = product_sum_sat(y, s, z, c, sat);
      end
      AXIS_Y: begin
        rx = product_sum_sat(x, c, z, s, sat);
        rz = product_sum_sat(x, -s, z, c, sat);
      end
      AXIS_Z: begin
        rx = product_sum_sat(x, c, y, -s, sat);
        ry = product_sum_sat(x, s, y, c, sat);
      end
      default: begin
      end
    endcase
    r.x   = rx[31:0];
    r.y   = ry[31:0];
    r.z   = rz[31:0];
    r.sat = sat;
    return r;
  endfunction

  function automatic int check_field(input string name, input logic [31:0] exp_v,
                                     input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        rotated_q.push_back(rotate_vector(s_axis_tuser_i, s_axis_tdata_i[15:0],
                                          s_axis_tdata_i[47:16], s_axis_tdata_i[79:48],
                                          s_axis_tdata_i[111:80]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.x   = m_axis_tdata_i[31:0];
        got.y   = m_axis_tdata_i[63:32];
        got.z   = m_axis_tdata_i[95:64];
        got.sat = m_axis_tuser_i[0];
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h %h %h sat %b",
                   $time, got.x, got.y, got.z, got.sat);
          failures++;
        end else begin
          want = rotated_q.pop_front();
          failures += check_field("out_x", want.x, got.x);
          failures += check_field("out_y", want.y, got.y);
          failures += check_field("out_z", want.z, got.z);
          failures += check_field("saturated", 32'(want.sat), 32'(got.sat));
        end
      end
      fail_count_o <= failures;
      pending_o    <= rotated_q.size();
    end
  end

endmodule

[verif/vector3_axis_rotation_unit_test.sv]
// top of the vector axis rotation unit test: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 1ps

module vector3_axis_rotation_unit_test;
  import vr3_pkg::*;

  localparam int          COORD_W      = COORD_WIDTH_DEF;
  localparam int          CORDIC_STEPS = TRIG_STEPS_DEF;
  localparam int          FULL_TURN    = 23040;
  localparam int          QUARTER_TURN = 5760;
  localparam int          RANDOM_ITEMS = 1850;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [1:0]  AXIS_UNUSED  = 2'd3;
  localparam field_t      FIELD_MAX    = 32'sh7fffffff;
  localparam field_t      FIELD_MIN    = 32'sh80000000;
  localparam field_t      ONE          = 32'sh00010000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [111:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [95:0]  m_axis_tdata_o;
  logic [0:0]   m_axis_tuser_o;

  int fail_count;
  int pending_count;
  int cycle_count;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  vector3_axis_rotation_unit #(
    .COORD_WIDTH(COORD_W),
    .TRIG_STEPS (CORDIC_STEPS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  vector3_axis_rotation_unit_checker #(
    .COORD_WIDTH(COORD_W),
    .TRIG_STEPS (CORDIC_STEPS)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 2) != 0);
        @(posedge clk_i);
      end
    end
  end

  task automatic offer_vector(input logic [1:0] axis, input logic signed [15:0] angle,
                              input field_t x, input field_t y, input field_t z);
    while (!calm && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= axis;
    s_axis_tdata_i  <= {z, y, x, angle};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  function automatic logic [1:0] pick_axis();
    if ($urandom_range(0, 15) == 0) return AXIS_UNUSED;
    return 2'($urandom_range(AXIS_X, AXIS_Z));
  endfunction

  function automatic logic signed [15:0] pick_angle();
    int          a;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      a = int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
    end else if (r < 8) begin
      // near the multiples of 90 degrees, where the fold changes
      a = int'($urandom_range(0, 8)) * QUARTER_TURN - FULL_TURN
          + int'($urandom_range(0, 4)) - 2;
    end else begin
      a = $urandom;
    end
    return a[15:0];
  endfunction

  function automatic field_t pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    if (r < 8) return $urandom;
    case ($urandom_range(0, 4))
      0:       return FIELD_MAX;
      1:       return FIELD_MIN;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  initial begin
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    offer_vector(AXIS_X, 0, ONE, 2 * ONE, 3 * ONE);
    offer_vector(AXIS_Y, QUARTER_TURN, ONE, -ONE, 5 * ONE);
    offer_vector(AXIS_Z, -QUARTER_TURN, 7 * ONE, -3 * ONE, ONE);
    offer_vector(AXIS_X, 2 * QUARTER_TURN, ONE, 2 * ONE, -4 * ONE);
    offer_vector(AXIS_Y, -2 * QUARTER_TURN, -ONE, ONE, ONE);
    offer_vector(AXIS_Z, 3 * QUARTER_TURN, 9 * ONE, ONE, 0);
    offer_vector(AXIS_X, FULL_TURN, ONE, ONE, ONE);
    offer_vector(AXIS_Y, -FULL_TURN, 3 * ONE, 0, -ONE);
    offer_vector(AXIS_Z, 16'sh7fff, ONE, 2 * ONE, 0);
    offer_vector(AXIS_X, 16'sh8000, 0, ONE, -2 * ONE);
    offer_vector(AXIS_Y, QUARTER_TURN + 1, ONE, ONE, ONE);
    offer_vector(AXIS_Z, -QUARTER_TURN - 1, -ONE, 4 * ONE, ONE);
    // 45 degrees on full-scale coordinates clips
    offer_vector(AXIS_Z, QUARTER_TURN / 2, FIELD_MAX, FIELD_MAX, FIELD_MIN);
    offer_vector(AXIS_X, QUARTER_TURN / 2, FIELD_MAX, FIELD_MIN, FIELD_MIN);
    offer_vector(AXIS_Y, -QUARTER_TURN / 2, FIELD_MAX, FIELD_MAX, FIELD_MIN);
    offer_vector(AXIS_UNUSED, 1234, FIELD_MAX, FIELD_MIN, -1);
    offer_vector(AXIS_X, 0, FIELD_MAX, FIELD_MIN, FIELD_MAX);
    offer_vector(AXIS_Z, 2 * QUARTER_TURN, FIELD_MIN, FIELD_MIN, 0);
    offer_vector(AXIS_Y, 1, 0, 0, 0);
    offer_vector(AXIS_X, -1, -1, 1, -1);
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 500 && n < 800);
      if (n == 1100) hold_req = 1'b1;
      if (n == 1400) drain_results();
      offer_vector(pick_axis(), pick_angle(), pick_coord(), pick_coord(), pick_coord());
    end
    calm = 1'b0;
    drain_results();
    repeat (CORDIC_STEPS + 20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
